// ===== rtl/core/evr_pkg.sv =====
`default_nettype none
package evr_pkg;

  // field and datapath widths fixed by the interface
  localparam int TIME_W = 48;
  localparam int VAL_W  = 32;
  localparam int DUR_W  = 16;
  localparam int MODE_W = 3;
  // duration in microseconds is at most 65535 * 1000 < 2^26
  localparam int SPAN_W = 26;
  // signed multiplicand width, holds the 33-bit value difference
  localparam int MA_W   = 34;
  localparam int DUR_SCALE = 1000;

  // item operations
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // easing curves
  localparam logic [MODE_W-1:0] MODE_LINEAR      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_IN_QUAD     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_OUT_QUAD    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_INOUT_QUAD  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_IN_CUBIC    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_OUT_CUBIC   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_INOUT_CUBIC = 3'd6;

  // register map, word index
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_MODE     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DURATION = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_START    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_END      = 2'd3;

  localparam logic [MODE_W-1:0] MODE_RESET = MODE_INOUT_QUAD;
  localparam logic [DUR_W-1:0]  DUR_RESET  = 16'd250;

endpackage
`default_nettype wire

// ===== rtl/core/evr_div.sv =====
`default_nettype none
module evr_div
  import evr_pkg::*;
#(
  parameter int FRAC = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [SPAN_W-1:0] dividend,
  input  wire logic [SPAN_W-1:0] divisor,
  output logic                   done,
  output logic [FRAC-1:0]        quotient
);

  localparam int CW = $clog2(FRAC + 1);

  logic [CW-1:0]     cnt;
  logic              busy;
  logic [SPAN_W-1:0] rem;
  logic [SPAN_W-1:0] dvs;
  logic [SPAN_W:0]   shifted;
  logic              fits;

  // one quotient bit a cycle, dividend below divisor so remainder stays narrow
  assign shifted = {rem, 1'b0};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(FRAC);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= SPAN_W'(shifted - {1'b0, dvs});
      end else begin
        rem <= shifted[SPAN_W-1:0];
      end
      quotient <= {quotient[FRAC-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/evr_mul.sv =====
`default_nettype none
module evr_mul
  import evr_pkg::*;
#(
  parameter int FRAC = 16
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic signed [MA_W-1:0]    a,
  input  wire logic [FRAC+1:0]           b,
  output logic signed [MA_W+FRAC+1:0]    p
);

  localparam int PW = MA_W + FRAC + 2;

  logic signed [FRAC+2:0] b_s;
  logic signed [PW:0]     full;

  // signed by unsigned, product registered
  assign b_s  = {1'b0, b};
  assign full = a * b_s;

  always_ff @(posedge clk) begin
    if (en) begin
      p <= full[PW-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/eased_value_ramp.sv =====
// eased_value_ramp: start items give their result in the cycle after acceptance.
// tick items step through span, end, clamp, divide, ease1, ease2, ease3, mix, num and
// out states, set by the serial divider (one progress bit a cycle) and the shared
// registered multiplier; the divide state is skipped when progress is zero or full.
// one tick in flight, next item taken back in idle; start items every cycle unless stalled.
// synchronous active-high reset: register defaults, begin time and last progress cleared
`default_nettype none
module eased_value_ramp
  import evr_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // item input
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    operation,
  input  wire logic [TIME_W-1:0]       frame_time_us,
  // result output
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [VAL_W-1:0]      output_value,
  output logic                         running,
  output logic                         updated,
  // register port
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [3:0]              paddr,
  input  wire logic [31:0]             pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int F  = FRACTION_BITS;
  localparam int PW = MA_W + F + 2;

  // sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SPAN  = 4'd1;
  localparam logic [3:0] S_END   = 4'd2;
  localparam logic [3:0] S_CLAMP = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_EASE1 = 4'd5;
  localparam logic [3:0] S_EASE2 = 4'd6;
  localparam logic [3:0] S_EASE3 = 4'd7;
  localparam logic [3:0] S_MIX   = 4'd8;
  localparam logic [3:0] S_NUM   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  // one in progress format (F+1 bits) and one/two in F+2 bits
  localparam logic [F:0]   ONE_P  = {1'b1, {F{1'b0}}};
  localparam logic [F+1:0] ONE_W  = {2'b01, {F{1'b0}}};
  localparam logic [F+1:0] TWO_W  = {2'b10, {F{1'b0}}};
  localparam logic [F:0]   ROUND  = {1'b0, {F{1'b1}}};

  logic [3:0] state;

  // configuration registers
  logic [MODE_W-1:0]       easing_mode;
  logic [DUR_W-1:0]        duration_ms;
  logic signed [VAL_W-1:0] start_value;
  logic signed [VAL_W-1:0] end_value;
  logic                    cfg_wr;

  // ramp state kept between items
  logic [TIME_W-1:0] ramp_begin;
  logic [F:0]        prev_progress;
  logic              prev_valid;

  // per-item working registers
  logic [TIME_W-1:0] t_in;
  logic [SPAN_W-1:0] span;
  logic [TIME_W:0]   window_end;
  logic [F:0]        progress;
  logic [F+1:0]      cube_base;
  logic              lower_half;
  logic [F:0]        alpha;
  logic              upd;
  logic signed [PW-1:0] num;

  // combinational helpers
  logic              accept;
  logic              out_free;
  logic              is_cubic;
  logic              at_end;
  logic              at_begin;
  logic [TIME_W-1:0] elapsed;
  logic              div_start;
  logic              div_done;
  logic [F-1:0]      div_q;
  logic [F+1:0]      twox;
  logic [F+1:0]      x_w;
  logic [F+1:0]      q_w;
  logic              half_n;
  logic [F+1:0]      ea;
  logic [F+1:0]      eb;
  logic [F+1:0]      base_n;
  logic [F:0]        cube_res;
  logic [2*F+1:0]    quad_sum;
  logic [F:0]        alpha_n;
  logic              mul_en;
  logic signed [MA_W-1:0] mul_a;
  logic [F+1:0]      mul_b;
  logic signed [PW-1:0]   mul_p;
  logic signed [VAL_W:0]  delta;
  logic signed [PW-1:0]   num_n;
  logic signed [PW-1:0]   num_r;

  // ---------------------------------------------------------------------------
  // register port: zero-wait, word addressed
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      easing_mode <= MODE_RESET;
      duration_ms <= DUR_RESET;
      start_value <= '0;
      end_value   <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MODE:     easing_mode <= pwdata[MODE_W-1:0];
        REG_DURATION: duration_ms <= pwdata[DUR_W-1:0];
        REG_START:    start_value <= pwdata;
        REG_END:      end_value   <= pwdata;
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MODE:     prdata = {{(32-MODE_W){1'b0}}, easing_mode};
      REG_DURATION: prdata = {{(32-DUR_W){1'b0}}, duration_ms};
      REG_START:    prdata = start_value;
      REG_END:      prdata = end_value;
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshake: take an item only in idle and when the result slot can take one
  // ---------------------------------------------------------------------------
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  assign is_cubic = (easing_mode == MODE_IN_CUBIC) || (easing_mode == MODE_OUT_CUBIC) ||
                    (easing_mode == MODE_INOUT_CUBIC);

  // ---------------------------------------------------------------------------
  // window clamp: compares against begin and end of the ramp
  // ---------------------------------------------------------------------------
  assign at_end    = {1'b0, t_in} >= window_end;
  assign at_begin  = t_in <= ramp_begin;
  assign elapsed   = t_in - ramp_begin;
  // strictly inside the window, so elapsed < span and fits SPAN_W bits
  assign div_start = (state == S_CLAMP) && !at_end && !at_begin;

  evr_div #(
    .FRAC     (F)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (elapsed[SPAN_W-1:0]),
    .divisor  (span),
    .done     (div_done),
    .quotient (div_q)
  );

  // ---------------------------------------------------------------------------
  // easing operands: first product of each curve
  // ---------------------------------------------------------------------------
  assign twox   = {progress, 1'b0};
  assign x_w    = {1'b0, progress};
  assign half_n = twox < ONE_W;
  assign q_w    = twox - ONE_W;

  always_comb begin
    ea     = x_w;
    eb     = x_w;
    base_n = x_w;
    case (easing_mode)
      MODE_OUT_QUAD: begin
        eb = TWO_W - x_w;
      end
      MODE_INOUT_QUAD: begin
        if (!half_n) begin
          ea = q_w;
          eb = TWO_W - q_w;
        end
      end
      MODE_OUT_CUBIC: begin
        base_n = ONE_W - x_w;
      end
      MODE_INOUT_CUBIC: begin
        base_n = half_n ? twox : TWO_W - twox;
      end
      default: ;
    endcase
    if (is_cubic) begin
      ea = base_n;
      eb = base_n;
    end
  end

  // ---------------------------------------------------------------------------
  // easing result from the last product
  // ---------------------------------------------------------------------------
  assign cube_res = mul_p[2*F:F];
  assign quad_sum = {2'b01, {(2*F){1'b0}}} + mul_p[2*F+1:0];

  always_comb begin
    case (easing_mode)
      MODE_IN_QUAD:     alpha_n = mul_p[2*F:F];
      MODE_OUT_QUAD:    alpha_n = mul_p[2*F:F];
      MODE_INOUT_QUAD:  alpha_n = lower_half ? mul_p[2*F-1:F-1] : quad_sum[2*F+1:F+1];
      MODE_IN_CUBIC:    alpha_n = cube_res;
      MODE_OUT_CUBIC:   alpha_n = ONE_P - cube_res;
      MODE_INOUT_CUBIC: alpha_n = lower_half ? {1'b0, cube_res[F:1]}
                                             : ONE_P - {1'b0, cube_res[F:1]};
      default:          alpha_n = progress;
    endcase
  end

  // ---------------------------------------------------------------------------
  // shared multiplier: span, easing products, interpolation
  // ---------------------------------------------------------------------------
  assign delta = {end_value[VAL_W-1], end_value} - {start_value[VAL_W-1], start_value};

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      S_SPAN: begin
        mul_en = 1'b1;
        mul_a  = {{(MA_W-DUR_W){1'b0}}, duration_ms};
        mul_b  = (F+2)'(DUR_SCALE);
      end
      S_EASE1: begin
        mul_en = 1'b1;
        mul_a  = {{(MA_W-F-2){1'b0}}, ea};
        mul_b  = eb;
      end
      S_EASE2: begin
        // cube: square already scaled down, times the base again
        mul_en = is_cubic;
        mul_a  = {{(MA_W-F-2){1'b0}}, mul_p[2*F+1:F]};
        mul_b  = cube_base;
      end
      S_MIX: begin
        mul_en = 1'b1;
        mul_a  = {delta[VAL_W], delta};
        mul_b  = {1'b0, alpha};
      end
      default: ;
    endcase
  end

  evr_mul #(
    .FRAC (F)
  ) u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .p    (mul_p)
  );

  // start * one + delta * alpha, then divide by one truncating toward zero
  assign num_n = (PW'(start_value) <<< F) + mul_p;
  assign num_r = num[PW-1] ? num + PW'(ROUND) : num;

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ramp_begin    <= '0;
      prev_progress <= '0;
      prev_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (operation == OP_START) begin
              // new ramp: result is the start value straight away
              ramp_begin <= frame_time_us;
              prev_valid <= 1'b0;
              out_valid  <= 1'b1;
            end else begin
              state <= S_SPAN;
            end
          end
        end
        S_SPAN:  state <= S_END;
        S_END:   state <= S_CLAMP;
        S_CLAMP: state <= div_start ? S_DIV : S_EASE1;
        S_DIV: begin
          if (div_done) begin
            state <= S_EASE1;
          end
        end
        S_EASE1: begin
          // progress repeated: keep record, flag not updated
          if (!(prev_valid && prev_progress == progress)) begin
            prev_progress <= progress;
            prev_valid    <= 1'b1;
          end
          state <= S_EASE2;
        end
        S_EASE2: state <= S_EASE3;
        S_EASE3: state <= S_MIX;
        S_MIX:   state <= S_NUM;
        S_NUM:   state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      t_in <= frame_time_us;
      if (operation == OP_START) begin
        output_value <= start_value;
        running      <= 1'b1;
        updated      <= 1'b0;
      end
    end
    if (state == S_END) begin
      span       <= mul_p[SPAN_W-1:0];
      window_end <= {1'b0, ramp_begin} + (TIME_W+1)'(mul_p[SPAN_W-1:0]);
    end
    if (state == S_CLAMP) begin
      // clamped to the end (also zero duration) gives full progress
      if (at_end || (at_begin && span == '0)) begin
        progress <= ONE_P;
      end else if (at_begin) begin
        progress <= '0;
      end
    end
    if (state == S_DIV && div_done) begin
      progress <= {1'b0, div_q};
    end
    if (state == S_EASE1) begin
      upd        <= !(prev_valid && prev_progress == progress);
      lower_half <= half_n;
      cube_base  <= base_n;
    end
    if (state == S_EASE3) begin
      alpha <= alpha_n;
    end
    if (state == S_NUM) begin
      num <= num_n;
    end
    if (state == S_OUT && out_free) begin
      output_value <= num_r[F+VAL_W-1:F];
      running      <= !progress[F];
      updated      <= upd;
    end
  end

endmodule
`default_nettype wire
